/* design/hsb_to_rgb_converter_assert.svh */
// assertion macros shared by the hsb to rgb converter modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef HSB_TO_RGB_CONVERTER_ASSERT_SVH
`define HSB_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/hsbrgb_pkg.sv */
// types, widths and sector codes for the hsb to rgb converter
// no dependencies
`default_nettype none

package hsbrgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = FRAC_BITS;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SEC_W     = 3;

    localparam logic [VAL_W-1:0] ONE_V = VAL_W'(1) << FRAC_BITS;

    typedef enum logic [SEC_W-1:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [VAL_W-1:0] saturation;
        logic [VAL_W-1:0] brightness;
        logic [VAL_W-1:0] alpha;
    } hsb_t;

    // after clamping and sector split
    typedef struct packed {
        sector_t          sector;
        logic [VAL_W-1:0] f;
        logic [VAL_W-1:0] one_minus_f;
        logic [VAL_W-1:0] s;
        logic [VAL_W-1:0] one_minus_s;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] alpha;
    } stage1_t;

    // after the fraction products
    typedef struct packed {
        sector_t          sector;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] fs;
        logic [VAL_W-1:0] fns;
        logic [VAL_W-1:0] alpha;
    } stage2_t;

    // after the brightness products
    typedef struct packed {
        sector_t          sector;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] p;
        logic [VAL_W-1:0] q;
        logic [VAL_W-1:0] t;
        logic [VAL_W-1:0] alpha;
    } stage3_t;

    typedef struct packed {
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
        logic [VAL_W-1:0] alpha;
    } rgb_t;

endpackage

`default_nettype wire

/* design/hsbrgb_hsb_if.sv */
// input channel: valid, ready and one hsb item
// depends on hsbrgb_pkg
`default_nettype none

interface hsbrgb_hsb_if;
    import hsbrgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
    logic [VAL_W-1:0] alpha_in;

    modport source (output valid, hue, saturation, brightness, alpha_in, input ready);
    modport sink   (input valid, hue, saturation, brightness, alpha_in, output ready);
endinterface

`default_nettype wire

/* design/hsbrgb_rgb_if.sv */
// output channel: valid, ready and one rgb item
// depends on hsbrgb_pkg
`default_nettype none

interface hsbrgb_rgb_if;
    import hsbrgb_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

`default_nettype wire

/* design/hsbrgb_front.sv */
// first stage: clamps saturation and brightness, splits hue into sector and fraction
// depends on hsbrgb_pkg
`default_nettype none

module hsbrgb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  hsbrgb_pkg::hsb_t   in_data,
    output logic               s1_valid,
    output hsbrgb_pkg::stage1_t s1_data
);
    import hsbrgb_pkg::*;

    logic             valid_reg;
    stage1_t          data_reg;
    stage1_t          data_next;
    logic [HUE_W+2:0] h6;
    logic [HUE_W+2:0] hue_ext;

    always_comb
    begin
        hue_ext = {3'b000, in_data.hue};
        // hue * 6 as the sum of two shifted copies
        h6 = (hue_ext << 2) + (hue_ext << 1);

        data_next.sector      = sector_t'(h6[HUE_W+2:HUE_W]);
        data_next.f           = {1'b0, h6[HUE_W-1:0]};
        data_next.one_minus_f = ONE_V - {1'b0, h6[HUE_W-1:0]};
        data_next.s           = (in_data.saturation > ONE_V) ? ONE_V : in_data.saturation;
        data_next.one_minus_s = ONE_V - data_next.s;
        data_next.b           = (in_data.brightness > ONE_V) ? ONE_V : in_data.brightness;
        data_next.alpha       = in_data.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

`default_nettype wire

/* design/hsbrgb_prod.sv */
// second and third stages: fraction products, then brightness products
// depends on hsbrgb_pkg and the assertion macro header
`default_nettype none
`include "hsb_to_rgb_converter_assert.svh"

module hsbrgb_prod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                s1_valid,
    input  hsbrgb_pkg::stage1_t s1_data,
    output logic                s3_valid,
    output hsbrgb_pkg::stage3_t s3_data
);
    import hsbrgb_pkg::*;

    logic              s2_valid_reg;
    stage2_t           s2_reg;
    stage2_t           s2_next;
    logic              s3_valid_reg;
    stage3_t           s3_reg;
    stage3_t           s3_next;
    logic [PROD_W-1:0] fs_prod;
    logic [PROD_W-1:0] fns_prod;
    logic [PROD_W-1:0] p_prod;
    logic [PROD_W-1:0] q_prod;
    logic [PROD_W-1:0] t_prod;

    // f*s, (1-f)*s and b*(1-s), each truncated
    always_comb
    begin
        fs_prod  = PROD_W'(s1_data.f) * PROD_W'(s1_data.s);
        fns_prod = PROD_W'(s1_data.one_minus_f) * PROD_W'(s1_data.s);
        p_prod   = PROD_W'(s1_data.b) * PROD_W'(s1_data.one_minus_s);

        s2_next.sector = s1_data.sector;
        s2_next.b      = s1_data.b;
        s2_next.p      = p_prod[2*FRAC_BITS:FRAC_BITS];
        s2_next.fs     = fs_prod[2*FRAC_BITS:FRAC_BITS];
        s2_next.fns    = fns_prod[2*FRAC_BITS:FRAC_BITS];
        s2_next.alpha  = s1_data.alpha;
    end

    // b*(1-f*s) and b*(1-(1-f)*s)
    always_comb
    begin
        q_prod = PROD_W'(s2_reg.b) * PROD_W'(ONE_V - s2_reg.fs);
        t_prod = PROD_W'(s2_reg.b) * PROD_W'(ONE_V - s2_reg.fns);

        s3_next.sector = s2_reg.sector;
        s3_next.b      = s2_reg.b;
        s3_next.p      = s2_reg.p;
        s3_next.q      = q_prod[2*FRAC_BITS:FRAC_BITS];
        s3_next.t      = t_prod[2*FRAC_BITS:FRAC_BITS];
        s3_next.alpha  = s2_reg.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign s3_valid = s3_valid_reg;
    assign s3_data  = s3_reg;

    // no derived channel may exceed the brightness
    `ASSERT_IMPLIES(a_prod_below_bri, clk, rst_n, s3_valid_reg,
        s3_reg.p <= s3_reg.b && s3_reg.q <= s3_reg.b && s3_reg.t <= s3_reg.b)

endmodule

`default_nettype wire

/* design/hsbrgb_sel.sv */
// last stage: picks channel order by sector into the output register
// depends on hsbrgb_pkg
`default_nettype none

module hsbrgb_sel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                s3_valid,
    input  hsbrgb_pkg::stage3_t s3_data,
    output logic                out_valid,
    output hsbrgb_pkg::rgb_t    out_data
);
    import hsbrgb_pkg::*;

    logic valid_reg;
    rgb_t data_reg;
    rgb_t data_next;

    always_comb
    begin
        data_next.alpha = s3_data.alpha;
        case (s3_data.sector)
            SEC_RED_YELLOW:
            begin
                data_next.red = s3_data.b; data_next.green = s3_data.t; data_next.blue = s3_data.p;
            end
            SEC_YELLOW_GREEN:
            begin
                data_next.red = s3_data.q; data_next.green = s3_data.b; data_next.blue = s3_data.p;
            end
            SEC_GREEN_CYAN:
            begin
                data_next.red = s3_data.p; data_next.green = s3_data.b; data_next.blue = s3_data.t;
            end
            SEC_CYAN_BLUE:
            begin
                data_next.red = s3_data.p; data_next.green = s3_data.q; data_next.blue = s3_data.b;
            end
            SEC_BLUE_MAGENTA:
            begin
                data_next.red = s3_data.t; data_next.green = s3_data.p; data_next.blue = s3_data.b;
            end
            SEC_MAGENTA_RED:
            begin
                data_next.red = s3_data.b; data_next.green = s3_data.p; data_next.blue = s3_data.q;
            end
            default:
            begin
                data_next.red = s3_data.b; data_next.green = s3_data.p; data_next.blue = s3_data.q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* design/hsb_to_rgb_converter.sv */
// hsb to rgb converter: four register stages, one item per clock while the output is not stalled
// path: an accepted item goes through the front, s2 and s3 registers into the output register
// throughput: 1 item per cycle; the whole pipe advances together, held while
// the output item is not taken, so input ready means output empty or being taken
// reset: asynchronous active-low clears all stage valid bits, no payload reset
// depends on hsbrgb_pkg, hsbrgb_hsb_if, hsbrgb_rgb_if and the stage modules
`default_nettype none
`include "hsb_to_rgb_converter_assert.svh"

module hsb_to_rgb_converter (
    input  logic          clk,
    input  logic          rst_n,
    hsbrgb_hsb_if.sink    hsb,
    hsbrgb_rgb_if.source  rgb
);
    import hsbrgb_pkg::*;

    logic    en;
    hsb_t    in_data;
    logic    s1_valid;
    stage1_t s1_data;
    logic    s3_valid;
    stage3_t s3_data;
    logic    out_valid;
    rgb_t    out_data;

    // pipe moves when the output register is empty or being taken
    assign en        = !out_valid || rgb.ready;
    assign hsb.ready = en;

    assign in_data.hue        = hsb.hue;
    assign in_data.saturation = hsb.saturation;
    assign in_data.brightness = hsb.brightness;
    assign in_data.alpha      = hsb.alpha_in;

    hsbrgb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (hsb.valid),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    hsbrgb_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s3_valid (s3_valid),
        .s3_data  (s3_data)
    );

    hsbrgb_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s3_valid  (s3_valid),
        .s3_data   (s3_data),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign rgb.valid     = out_valid;
    assign rgb.red       = out_data.red;
    assign rgb.green     = out_data.green;
    assign rgb.blue      = out_data.blue;
    assign rgb.alpha_out = out_data.alpha;

    // a held output item must back-pressure the input
    `ASSERT_IMPLIES(a_stall_reaches_input, clk, rst_n, rgb.valid && !rgb.ready, !hsb.ready)

    // an accepted item lands in the first stage
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, hsb.valid && hsb.ready, s1_valid)

    // channels never exceed one
    `ASSERT_IMPLIES(a_out_in_range, clk, rst_n, rgb.valid,
        rgb.red <= ONE_V && rgb.green <= ONE_V && rgb.blue <= ONE_V)

endmodule

`default_nettype wire

/* test/tb_hsb_to_rgb_converter.sv */
// self-checking testbench for hsb_to_rgb_converter: random pixels, random flow control
// depends on hsbrgb_pkg, hsbrgb_hsb_if, hsbrgb_rgb_if and the converter rtl
`timescale 1ns / 1ps

module tb_hsb_to_rgb_converter;
    import hsbrgb_pkg::*;

    localparam int          HUE_SECTORS = 6;
    localparam int          ONE_I       = 1 << FRAC_BITS;
    localparam int          VAL_MAX     = (1 << VAL_W) - 1;
    localparam logic [63:0] UNIT        = 64'd1 << FRAC_BITS;
    localparam int          N_RANDOM    = 1600;
    localparam int          MAX_WAIT    = 18;
    localparam int          DRAIN       = 12;
    localparam int          LIMIT       = 400000;

    logic clk;
    logic rst_n;

    hsbrgb_hsb_if hsb_ch ();
    hsbrgb_rgb_if rgb_ch ();

    hsb_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsb   (hsb_ch),
        .rgb   (rgb_ch)
    );

    hsb_t        pixels_to_send[$];
    rgb_t        rgb_due[$];
    int unsigned n_total;
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned n_clamped;
    bit          in_taken;
    bit          out_taken;
    bit          in_calm;
    bit          out_calm;
    int unsigned gap_left;
    int unsigned stall_left;

    // expected colour for one pixel, all products floored to FRAC_BITS
    function automatic rgb_t colour_of(hsb_t px);
        logic [63:0] h6;
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] b;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] fs;
        logic [63:0] fns;
        sector_t     sec;
        rgb_t        c;
        s   = (px.saturation > ONE_V) ? UNIT : 64'(px.saturation);
        b   = (px.brightness > ONE_V) ? UNIT : 64'(px.brightness);
        h6  = 64'(px.hue) * HUE_SECTORS;
        sec = sector_t'(h6 >> FRAC_BITS);
        f   = h6 & (UNIT - 1);
        p   = (b * (UNIT - s)) >> FRAC_BITS;
        fs  = (f * s) >> FRAC_BITS;
        q   = (b * (UNIT - fs)) >> FRAC_BITS;
        fns = ((UNIT - f) * s) >> FRAC_BITS;
        t   = (b * (UNIT - fns)) >> FRAC_BITS;
        case (sec)
            SEC_RED_YELLOW:
            begin
                c.red = VAL_W'(b); c.green = VAL_W'(t); c.blue = VAL_W'(p);
            end
            SEC_YELLOW_GREEN:
            begin
                c.red = VAL_W'(q); c.green = VAL_W'(b); c.blue = VAL_W'(p);
            end
            SEC_GREEN_CYAN:
            begin
                c.red = VAL_W'(p); c.green = VAL_W'(b); c.blue = VAL_W'(t);
            end
            SEC_CYAN_BLUE:
            begin
                c.red = VAL_W'(p); c.green = VAL_W'(q); c.blue = VAL_W'(b);
            end
            SEC_BLUE_MAGENTA:
            begin
                c.red = VAL_W'(t); c.green = VAL_W'(p); c.blue = VAL_W'(b);
            end
            default:
            begin
                c.red = VAL_W'(b); c.green = VAL_W'(p); c.blue = VAL_W'(q);
            end
        endcase
        c.alpha = px.alpha;
        return c;
    endfunction

    function automatic void add_pixel(int h, int s, int b, int a);
        hsb_t px;
        px.hue        = HUE_W'(h);
        px.saturation = VAL_W'(s);
        px.brightness = VAL_W'(b);
        px.alpha      = VAL_W'(a);
        pixels_to_send = {pixels_to_send, px};
    endfunction

    // saturation or brightness, weighted towards the corners and the clamp
    function automatic int level_draw();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return ONE_I;
            2:       return $urandom_range(ONE_I + 1, VAL_MAX);
            3:       return ONE_I - $urandom_range(0, 3);
            default: return $urandom_range(0, ONE_I);
        endcase
    endfunction

    // first hue of a sector: ceil(k * ONE / 6)
    function automatic int sector_start(int k);
        return (k * ONE_I + HUE_SECTORS - 1) / HUE_SECTORS;
    endfunction

    // per-item wait; now and then flips into a stretch with no waits at all
    function automatic int unsigned wait_draw(inout bit calm);
        if ($urandom_range(0, 99) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver: presents the next pending item after its drawn gap
    always @(negedge clk)
    begin
        if (!rst_n)
            hsb_ch.valid <= 1'b0;
        else if (!hsb_ch.valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                hsb_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (pixels_to_send.size() > 0)
            begin
                hsb_t px;
                px = pixels_to_send.pop_front();
                hsb_ch.hue        <= px.hue;
                hsb_ch.saturation <= px.saturation;
                hsb_ch.brightness <= px.brightness;
                hsb_ch.alpha_in   <= px.alpha;
                hsb_ch.valid      <= 1'b1;
                gap_left          <= wait_draw(in_calm);
            end
            else
                hsb_ch.valid <= 1'b0;
        end
    end

    // receiver: stalls for a drawn number of cycles after each result
    always @(negedge clk)
    begin
        if (!rst_n)
            rgb_ch.ready <= 1'b0;
        else if (out_taken)
        begin
            stall_left = wait_draw(out_calm);
            rgb_ch.ready <= (stall_left == 0);
        end
        else if (!rgb_ch.ready)
        begin
            if (stall_left > 0)
                stall_left--;
            rgb_ch.ready <= (stall_left == 0);
        end
    end

    // monitor: checks results first, then records what the accepted item should give
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= hsb_ch.valid && hsb_ch.ready;
            out_taken <= rgb_ch.valid && rgb_ch.ready;
            if (rgb_ch.valid && rgb_ch.ready)
            begin
                if (rgb_due.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                                 rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.alpha_out);
                end
                else
                begin
                    rgb_t want;
                    want = rgb_due.pop_front();
                    n_checked++;
                    if (rgb_ch.red !== want.red || rgb_ch.green !== want.green ||
                        rgb_ch.blue !== want.blue || rgb_ch.alpha_out !== want.alpha)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"mismatch on result %0d: ",
                                      "expected r=%0d g=%0d b=%0d a=%0d, ",
                                      "got r=%0d g=%0d b=%0d a=%0d"},
                                     n_checked, want.red, want.green, want.blue, want.alpha,
                                     rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.alpha_out);
                    end
                end
            end
            if (hsb_ch.valid && hsb_ch.ready)
            begin
                hsb_t px;
                px.hue        = hsb_ch.hue;
                px.saturation = hsb_ch.saturation;
                px.brightness = hsb_ch.brightness;
                px.alpha      = hsb_ch.alpha_in;
                rgb_due = {rgb_due, colour_of(px)};
                if (px.saturation > ONE_V || px.brightness > ONE_V)
                    n_clamped++;
                n_sent++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, rgb_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int h;
        rst_n             = 1'b0;
        hsb_ch.valid      = 1'b0;
        hsb_ch.hue        = '0;
        hsb_ch.saturation = '0;
        hsb_ch.brightness = '0;
        hsb_ch.alpha_in   = '0;
        rgb_ch.ready      = 1'b0;
        n_sent    = 0;
        n_checked = 0;
        n_bad     = 0;
        n_clamped = 0;
        gap_left   = 0;
        stall_left = 0;
        in_calm    = 1'b0;
        out_calm   = 1'b0;

        // corners of every field
        add_pixel(0, 0, 0, 0);
        add_pixel(0, ONE_I, ONE_I, ONE_I);
        add_pixel(ONE_I - 1, ONE_I, ONE_I, VAL_MAX);
        // first and last hue of each sector
        for (int k = 0; k < HUE_SECTORS; k++)
        begin
            add_pixel(sector_start(k), ONE_I, ONE_I / 2, ONE_I / 3);
            add_pixel(sector_start(k + 1) - 1, ONE_I * 3 / 4, ONE_I, ONE_I / 5);
        end
        // saturation and brightness beyond one get clamped
        add_pixel(5000, ONE_I + 1, ONE_I / 2, ONE_I);
        add_pixel(40000, VAL_MAX, 12345, 7);
        add_pixel(20000, ONE_I / 2, ONE_I + 1, 1);
        add_pixel(60000, 33333, VAL_MAX, ONE_I + 1);
        add_pixel(ONE_I / 2, VAL_MAX, VAL_MAX, ONE_I);
        add_pixel(ONE_I / 3, 0, ONE_I, 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                h = sector_start($urandom_range(0, HUE_SECTORS - 1)) + $urandom_range(0, 6) - 3;
            else
                h = $urandom_range(0, ONE_I - 1);
            add_pixel(h, level_draw(), level_draw(),
                      $urandom_range(0, 1) ? $urandom_range(0, VAL_MAX)
                                           : $urandom_range(0, ONE_I));
        end
        n_total = pixels_to_send.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge clk);
        while (rgb_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d pixels across all six hue sectors, %0d with a clamped level",
                 n_sent, n_clamped);
        $display("%0d results checked under random gaps and stalls, %0d mismatches",
                 n_checked, n_bad);
        if (n_bad == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
